// ===== hdl/rapp_pkg.sv =====
// Shared types, character codes and helpers for the RF amplifier poll/reply parser.
// No dependencies; imported by rapp_ctrl, rapp_emit and the top level.
`timescale 1ns / 1ps
`default_nettype none

package rapp_pkg;

  // Input item command codes
  typedef enum logic [1:0] {
    CMD_RX    = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_POWER = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  // Result kinds
  typedef enum logic [2:0] {
    K_TX     = 3'd0,
    K_TEMP   = 3'd1,
    K_POWER  = 3'd2,
    K_NORESP = 3'd3,
    K_SYNTAX = 3'd4,
    K_BADLVL = 3'd5,
    K_RECOV  = 3'd6
  } kind_t;

  // Reply parser phases
  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_SKIP    = 4'd1,
    PH_P_S     = 4'd2,
    PH_P_EQ    = 4'd3,
    PH_P_DIG   = 4'd4,
    PH_P_END   = 4'd5,
    PH_R_T     = 4'd6,
    PH_R_EQ    = 4'd7,
    PH_R_FIRST = 4'd8,
    PH_R_POS2  = 4'd9,
    PH_R_POS3  = 4'd10,
    PH_R_NEG1  = 4'd11,
    PH_R_NEG2  = 4'd12,
    PH_R_C     = 4'd13,
    PH_R_END   = 4'd14
  } phase_t;

  // Four-byte command that follows a decision
  typedef enum logic [1:0] {
    SEND_NONE  = 2'd0,
    SEND_POWER = 2'd1,
    SEND_POLL  = 2'd2
  } send_t;

  // Configuration register indexes
  localparam logic CFG_TIMEOUT = 1'b0;
  localparam logic CFG_ERR_LIM = 1'b1;

  localparam logic [3:0] TIMEOUT_RST = 4'd2;
  localparam logic [3:0] ERR_LIM_RST = 4'd4;

  // Character codes
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_FOUR  = 8'h34;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_QUERY = 8'h3F;

  // One accepted input transaction
  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] rx_byte;
    logic [2:0] power_level;
  } item_t;

  // Results caused by one transaction, in output order:
  // head report, recovered notice, then a four-byte command
  typedef struct packed {
    logic               head_vld;
    kind_t              head_kind;
    logic signed [10:0] head_temp;
    logic [2:0]         head_pw;
    logic               recov;
    send_t              send;
    logic [2:0]         send_lvl;
  } plan_t;

  function automatic logic is_eol(input logic [7:0] b);
    return (b == CH_CR) || (b == CH_LF);
  endfunction

  function automatic logic is_dig(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  function automatic logic is_ws(input logic [7:0] b);
    return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

  // Byte idx of a power or poll command
  function automatic logic [7:0] cmd_char(input send_t s, input logic [2:0] lvl,
                                         input logic [1:0] idx);
    logic [7:0] c;
    c = CH_CR;
    unique case (idx)
      2'd0: c = (s == SEND_POLL) ? CH_R : CH_P;
      2'd1: c = (s == SEND_POLL) ? CH_T : CH_S;
      2'd2: c = (s == SEND_POLL) ? CH_QUERY : (CH_ZERO + {5'd0, lvl});
      2'd3: c = CH_CR;
      default: c = CH_CR;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/rapp_ctrl.sv =====
// Link state and reply parser: updates state for one transaction and plans its results.
// Depends on rapp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rapp_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           fire,
  input  wire rapp_pkg::item_t item,
  input  wire logic [3:0]     timeout_ticks,
  input  wire logic [3:0]     error_report_limit,
  output rapp_pkg::plan_t     plan
);
  import rapp_pkg::*;

  phase_t     phase, phase_next;
  logic [9:0] temp_accum, temp_accum_next;
  logic       temp_negative, temp_negative_next;
  logic [2:0] power_digit, power_digit_next;
  logic       request_pending, request_pending_next;
  logic [3:0] ticks_waiting, ticks_waiting_next;
  logic [2:0] queued_power, queued_power_next;
  logic [3:0] error_count, error_count_next;

  logic        fin_bad, fin_reply, fin_pow, fin_temp, follow;
  logic [7:0]  b;
  logic        eol, dig;
  logic [13:0] acc_mul;
  logic [10:0] temp_val;

  assign b        = item.rx_byte;
  assign eol      = is_eol(b);
  assign dig      = is_dig(b);
  assign acc_mul  = {temp_accum, 3'b000} + {3'b000, temp_accum, 1'b0}
                    + {10'd0, b[3:0]};
  assign temp_val = temp_negative ? (~{1'b0, temp_accum} + 11'd1) : {1'b0, temp_accum};

  // Next state and result plan
  always_comb begin
    phase_next           = phase;
    temp_accum_next      = temp_accum;
    temp_negative_next   = temp_negative;
    power_digit_next     = power_digit;
    request_pending_next = request_pending;
    ticks_waiting_next   = ticks_waiting;
    queued_power_next    = queued_power;
    error_count_next     = error_count;
    plan      = '0;
    fin_bad   = 1'b0;
    fin_reply = 1'b0;
    fin_pow   = 1'b0;
    fin_temp  = 1'b0;
    follow    = 1'b0;

    if (fire) begin
      unique case (item.cmd)
        CMD_RX: begin
          // Parse one received byte
          unique case (phase)
            PH_IDLE: begin
              if (!is_ws(b)) begin
                if (b == CH_P) phase_next = PH_P_S;
                else if (b == CH_R) phase_next = PH_R_T;
                else fin_bad = 1'b1;
              end
            end
            PH_SKIP: if (eol) phase_next = PH_IDLE;
            PH_P_S: begin
              if (b == CH_S) phase_next = PH_P_EQ;
              else begin fin_bad = 1'b1; fin_reply = 1'b1; end
            end
            PH_P_EQ: begin
              if (b == CH_EQ) phase_next = PH_P_DIG;
              else begin fin_bad = 1'b1; fin_reply = 1'b1; end
            end
            PH_P_DIG: begin
              if ((b >= CH_ONE) && (b <= CH_FOUR)) begin
                power_digit_next = b[2:0];
                phase_next       = PH_P_END;
              end else begin
                fin_bad = 1'b1; fin_reply = 1'b1;
              end
            end
            PH_P_END: begin
              if (eol) fin_pow = 1'b1;
              else begin fin_bad = 1'b1; fin_reply = 1'b1; end
            end
            PH_R_T: begin
              if (b == CH_T) phase_next = PH_R_EQ;
              else begin fin_bad = 1'b1; fin_reply = 1'b1; end
            end
            PH_R_EQ: begin
              if (b == CH_EQ) phase_next = PH_R_FIRST;
              else begin fin_bad = 1'b1; fin_reply = 1'b1; end
            end
            PH_R_FIRST: begin
              if (dig) begin
                temp_accum_next    = {6'd0, b[3:0]};
                temp_negative_next = 1'b0;
                phase_next         = PH_R_POS2;
              end else if (b == CH_MINUS) begin
                temp_accum_next    = '0;
                temp_negative_next = 1'b1;
                phase_next         = PH_R_NEG1;
              end else begin
                fin_bad = 1'b1; fin_reply = 1'b1;
              end
            end
            PH_R_POS2, PH_R_POS3, PH_R_NEG1, PH_R_NEG2: begin
              if (dig) begin
                temp_accum_next = acc_mul[9:0];
                if (phase == PH_R_POS2) phase_next = PH_R_POS3;
                else if (phase == PH_R_NEG1) phase_next = PH_R_NEG2;
                else phase_next = PH_R_C;
              end else begin
                fin_bad = 1'b1; fin_reply = 1'b1;
              end
            end
            PH_R_C: begin
              if (b == CH_C) phase_next = PH_R_END;
              else begin fin_bad = 1'b1; fin_reply = 1'b1; end
            end
            PH_R_END: begin
              if (eol) fin_temp = 1'b1;
              else begin fin_bad = 1'b1; fin_reply = 1'b1; end
            end
            default: phase_next = PH_IDLE;
          endcase

          // Close the line: error, power report or temperature report
          if (fin_bad) begin
            if (error_count < error_report_limit) begin
              error_count_next = error_count + 4'd1;
              plan.head_vld    = 1'b1;
              plan.head_kind   = K_SYNTAX;
            end
            if (fin_reply) request_pending_next = 1'b0;
            phase_next = eol ? PH_IDLE : PH_SKIP;
            follow     = 1'b1;
          end
          if (fin_pow || fin_temp) begin
            plan.head_vld = 1'b1;
            if (fin_pow) begin
              plan.head_kind    = K_POWER;
              plan.head_pw      = power_digit;
              queued_power_next = '0;
            end else begin
              plan.head_kind = K_TEMP;
              plan.head_temp = temp_val;
            end
            if (error_count != 4'd0) begin
              error_count_next = '0;
              plan.recov       = 1'b1;
            end
            request_pending_next = 1'b0;
            phase_next           = PH_IDLE;
            follow               = 1'b1;
          end

          // Resend queued power request, or re-poll after a counted tick
          if (follow && !request_pending_next) begin
            if (queued_power_next != 3'd0) begin
              plan.send     = SEND_POWER;
              plan.send_lvl = queued_power_next;
            end else if (ticks_waiting_next != 4'd0) begin
              plan.send            = SEND_POLL;
              request_pending_next = 1'b1;
              ticks_waiting_next   = '0;
            end
          end
        end

        CMD_TICK: begin
          if (!request_pending) begin
            plan.send            = SEND_POLL;
            request_pending_next = 1'b1;
            ticks_waiting_next   = '0;
          end else begin
            // Count the tick, saturating, then check for timeout
            ticks_waiting_next = (ticks_waiting == 4'd15) ? ticks_waiting
                                                          : ticks_waiting + 4'd1;
            if (ticks_waiting_next >= timeout_ticks) begin
              if (error_count < error_report_limit) begin
                error_count_next = error_count + 4'd1;
                plan.head_vld    = 1'b1;
                plan.head_kind   = K_NORESP;
              end
              request_pending_next = 1'b0;
              if (queued_power != 3'd0) begin
                plan.send     = SEND_POWER;
                plan.send_lvl = queued_power;
              end else begin
                plan.send            = SEND_POLL;
                request_pending_next = 1'b1;
                ticks_waiting_next   = '0;
              end
            end
          end
        end

        CMD_POWER: begin
          if ((item.power_level < 3'd1) || (item.power_level > 3'd4)) begin
            plan.head_vld  = 1'b1;
            plan.head_kind = K_BADLVL;
          end else begin
            queued_power_next = item.power_level;
            if (!request_pending) begin
              plan.send     = SEND_POWER;
              plan.send_lvl = item.power_level;
            end
          end
        end

        CMD_NONE: begin
        end

        default: begin
        end
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      temp_accum      <= '0;
      temp_negative   <= 1'b0;
      power_digit     <= '0;
      request_pending <= 1'b0;
      ticks_waiting   <= '0;
      queued_power    <= '0;
      error_count     <= '0;
    end else begin
      phase           <= phase_next;
      temp_accum      <= temp_accum_next;
      temp_negative   <= temp_negative_next;
      power_digit     <= power_digit_next;
      request_pending <= request_pending_next;
      ticks_waiting   <= ticks_waiting_next;
      queued_power    <= queued_power_next;
      error_count     <= error_count_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rapp_emit.sv =====
// Result sequencer: holds the plan of one transaction; presents its results one per cycle unless stalled.
// Depends on rapp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rapp_emit (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                load,
  input  wire rapp_pkg::plan_t     plan,
  output logic                     can_load,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [2:0]               kind,
  output logic [7:0]               tx_byte,
  output logic signed [10:0]       temperature,
  output logic [2:0]               power_reported,
  output logic                     last
);
  import rapp_pkg::*;

  logic               head_pend;
  kind_t              head_kind;
  logic signed [10:0] head_temp;
  logic [2:0]         head_pw;
  logic               recov_pend;
  send_t              send;
  logic [2:0]         send_lvl;
  logic [1:0]         bidx;
  logic               pop;

  assign out_valid = head_pend || recov_pend || (send != SEND_NONE);
  assign pop       = out_valid && out_ready;
  assign can_load  = !out_valid || (out_ready && last);

  // Select the current result
  always_comb begin
    kind           = K_TX;
    tx_byte        = '0;
    temperature    = '0;
    power_reported = '0;
    last           = 1'b0;
    if (head_pend) begin
      kind           = head_kind;
      temperature    = head_temp;
      power_reported = head_pw;
      last           = !recov_pend && (send == SEND_NONE);
    end else if (recov_pend) begin
      kind = K_RECOV;
      last = (send == SEND_NONE);
    end else begin
      tx_byte = cmd_char(send, send_lvl, bidx);
      last    = (bidx == 2'd3);
    end
  end

  // Payload of the planned results
  always_ff @(posedge clk) begin
    if (load) begin
      head_kind <= plan.head_kind;
      head_temp <= plan.head_temp;
      head_pw   <= plan.head_pw;
      send_lvl  <= plan.send_lvl;
    end
  end

  // Advance through head, notice and command bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      head_pend  <= 1'b0;
      recov_pend <= 1'b0;
      send       <= SEND_NONE;
      bidx       <= '0;
    end else if (load) begin
      head_pend  <= plan.head_vld;
      recov_pend <= plan.recov;
      send       <= plan.send;
      bidx       <= '0;
    end else if (pop) begin
      if (head_pend) begin
        head_pend <= 1'b0;
      end else if (recov_pend) begin
        recov_pend <= 1'b0;
      end else begin
        bidx <= bidx + 2'd1;
        if (bidx == 2'd3) send <= SEND_NONE;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rf_amp_poll_and_reply_parser_core.sv =====
// Top level of the RF amplifier poll scheduler and reply parser.
// Depends on rapp_pkg, rapp_ctrl and rapp_emit.
//
//   Port group   Handshake              Payload
//   input        in_valid / in_ready    cmd, rx_byte, power_level
//   result       out_valid / out_ready  kind, tx_byte, temperature, power_reported, last
//   config       cfg_wr_en              cfg_index, cfg_data
//
// A transaction is registered at the input, then processed combinationally into a result plan
// that the result sequencer loads once it is free. A transaction yields 0 to 6 results, shown
// one at a time, so the input sustains one transaction per cycle while each yields at most one
// result and out_ready stays high. The result sequencer sets the rate otherwise.
// Reset clears link and parser state and loads timeout 2 and error limit 4.
// An output stall holds the current result and backs up into the input register.
`timescale 1ns / 1ps
`default_nettype none

module rf_amp_poll_and_reply_parser_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         cmd,
  input  wire logic [7:0]         rx_byte,
  input  wire logic [2:0]         power_level,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [2:0]              kind,
  output logic [7:0]              tx_byte,
  output logic signed [10:0]      temperature,
  output logic [2:0]              power_reported,
  output logic                    last,
  input  wire logic               cfg_wr_en,
  input  wire logic               cfg_index,
  input  wire logic [3:0]         cfg_data
);
  import rapp_pkg::*;

  logic       in_q_vld;
  item_t      in_q;
  logic       can_load;
  logic       fire;
  plan_t      plan;
  logic       plan_busy;
  logic [3:0] timeout_ticks;
  logic [3:0] error_report_limit;

  assign fire      = in_q_vld && can_load;
  assign in_ready  = !in_q_vld || can_load;
  assign plan_busy = plan.head_vld || plan.recov || (plan.send != SEND_NONE);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks      <= TIMEOUT_RST;
      error_report_limit <= ERR_LIM_RST;
    end else if (cfg_wr_en) begin
      if (cfg_index == CFG_TIMEOUT) timeout_ticks <= cfg_data;
      if (cfg_index == CFG_ERR_LIM) error_report_limit <= cfg_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_vld <= 1'b0;
    end else if (in_ready) begin
      in_q_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q.cmd         <= cmd_t'(cmd);
      in_q.rx_byte     <= rx_byte;
      in_q.power_level <= power_level;
    end
  end

  rapp_ctrl u_ctrl (
    .clk                (clk),
    .rst                (rst),
    .fire               (fire),
    .item               (in_q),
    .timeout_ticks      (timeout_ticks),
    .error_report_limit (error_report_limit),
    .plan               (plan)
  );

  rapp_emit u_emit (
    .clk            (clk),
    .rst            (rst),
    .load           (fire),
    .plan           (plan),
    .can_load       (can_load),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .kind           (kind),
    .tx_byte        (tx_byte),
    .temperature    (temperature),
    .power_reported (power_reported),
    .last           (last)
  );

  // An accepted transaction lands in the input register
  a_in_capture: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> in_q_vld)
    else $error("accepted transaction not captured");

  // A processed transaction with results presents them on the next cycle
  a_plan_shown: assert property (@(posedge clk) disable iff (rst)
    fire && plan_busy |=> out_valid)
    else $error("planned results not presented");

  // The final result of a transaction empties the sequencer unless a new plan loads
  a_last_drains: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last && !fire |=> !out_valid)
    else $error("results remain after final result");

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for the RF amplifier poll scheduler and reply parser.
// Depends on rapp_pkg (command, kind and phase codes, character codes, register indexes)
// and on rf_amp_poll_and_reply_parser_core.
`timescale 1ns / 1ps

module tb_top;
  import rapp_pkg::*;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int SETTLE_CYCLES   = 8;
  localparam int DRAIN_CYCLES    = 16;
  localparam int ITEMS_PER_PHASE = 18;
  localparam int HOLD_CYCLES     = 80;
  localparam int MAX_PRINTS      = 40;
  localparam int DIR_ROWS        = 28;
  localparam int NUM_PHASES      = 4;

  // Register settings and handshake mix per random phase
  localparam logic [3:0] TMO_SET [NUM_PHASES] = '{4'd1, 4'd15, 4'd3, 4'd2};
  localparam logic [3:0] LIM_SET [NUM_PHASES] = '{4'd0, 4'd15, 4'd2, 4'd1};
  localparam int IDLE_SET [NUM_PHASES]  = '{0, 69, 0, 12};
  localparam int STALL_SET [NUM_PHASES] = '{0, 0, 69, 12};

  localparam logic [31:0] NO_TX = 32'h0;

  typedef struct packed {
    kind_t              kind;
    logic [7:0]         tx;
    logic signed [10:0] temp;
    logic [2:0]         pw;
    logic               last;
  } link_out_t;

  // One directed transaction; n_typed > 0 means its results are written out here
  typedef struct packed {
    cmd_t               cmd;
    logic [7:0]         rx;
    logic [2:0]         lvl;
    logic [2:0]         n_typed;
    kind_t              kind;
    logic [31:0]        txs;
    logic signed [10:0] val;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_cmd = 2'd0;
  logic [7:0]         in_rx = 8'd0;
  logic [2:0]         in_lvl = 3'd0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [2:0]         kind;
  logic [7:0]         tx_byte;
  logic signed [10:0] temperature;
  logic [2:0]         power_reported;
  logic               last;
  logic               cfg_wr_en = 1'b0;
  logic               cfg_index = 1'b0;
  logic [3:0]         cfg_data = 4'd0;

  // Link state as the block should hold it
  phase_t     lk_phase  = PH_IDLE;
  logic [9:0] deg_acc   = 10'd0;
  logic       deg_neg   = 1'b0;
  logic [2:0] ps_digit  = 3'd0;
  logic       awaiting  = 1'b0;
  logic [3:0] tick_cnt  = 4'd0;
  logic [2:0] ps_queued = 3'd0;
  logic [3:0] err_cnt   = 4'd0;
  logic [3:0] tmo_ticks = TIMEOUT_RST;
  logic [3:0] err_limit = ERR_LIM_RST;

  link_out_t step_out[$];
  link_out_t typed_q[$];
  link_out_t link_out_q[$];

  dir_row_t dir_rows [DIR_ROWS];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_ask       = 0;
  int hold_taken     = 0;
  int hold_left      = 0;
  int items_sent     = 0;
  int results_seen   = 0;
  int fail_cnt       = 0;
  int cycles         = 0;

  rf_amp_poll_and_reply_parser_core DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .cmd            (in_cmd),
    .rx_byte        (in_rx),
    .power_level    (in_lvl),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .kind           (kind),
    .tx_byte        (tx_byte),
    .temperature    (temperature),
    .power_reported (power_reported),
    .last           (last),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Link behavior: results per accepted transaction
  // ---------------------------------------------------------------------------

  function automatic logic eol_b(input logic [7:0] b);
    return (b == CH_CR) || (b == CH_LF);
  endfunction

  function automatic logic digit_b(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  // Append one result; at most six per transaction
  function automatic void put(input kind_t k, input logic [7:0] tx,
                              input logic signed [10:0] t, input logic [2:0] pw);
    link_out_t r;
    if (step_out.size() >= 6) return;
    r.kind = k;
    r.tx   = tx;
    r.temp = t;
    r.pw   = pw;
    r.last = 1'b0;
    step_out.push_back(r);
  endfunction

  function automatic void send4(input logic [7:0] a, input logic [7:0] b,
                                input logic [7:0] c, input logic [7:0] d);
    put(K_TX, a, 11'sd0, 3'd0);
    put(K_TX, b, 11'sd0, 3'd0);
    put(K_TX, c, 11'sd0, 3'd0);
    put(K_TX, d, 11'sd0, 3'd0);
  endfunction

  function automatic void send_power();
    send4(CH_P, CH_S, CH_ZERO + {5'd0, ps_queued}, CH_CR);
  endfunction

  function automatic void send_poll();
    send4(CH_R, CH_T, CH_QUERY, CH_CR);
    awaiting = 1'b1;
    tick_cnt = 4'd0;
  endfunction

  // Emit an error only while under the limit
  function automatic void throttle(input kind_t k);
    if (err_cnt >= err_limit) return;
    err_cnt = err_cnt + 4'd1;
    put(k, 8'd0, 11'sd0, 3'd0);
  endfunction

  function automatic void recovered();
    if (err_cnt != 4'd0) begin
      err_cnt = 4'd0;
      put(K_RECOV, 8'd0, 11'sd0, 3'd0);
    end
  endfunction

  // Resend the queued power level, or poll if a tick was counted
  function automatic void after_line();
    if (awaiting) return;
    if (ps_queued != 3'd0) send_power();
    else if (tick_cnt != 4'd0) send_poll();
  endfunction

  function automatic void line_error(input logic [7:0] b, input logic in_reply);
    throttle(K_SYNTAX);
    if (in_reply) awaiting = 1'b0;
    lk_phase = eol_b(b) ? PH_IDLE : PH_SKIP;
    after_line();
  endfunction

  function automatic void rx_parse(input logic [7:0] b);
    logic signed [10:0] t;
    case (lk_phase)
      PH_IDLE: begin
        // drop leading whitespace
        if (!(b == CH_SPACE || (b >= CH_TAB && b <= CH_CR))) begin
          if (b == CH_P) lk_phase = PH_P_S;
          else if (b == CH_R) lk_phase = PH_R_T;
          else line_error(b, 1'b0);
        end
      end
      PH_SKIP: begin
        if (eol_b(b)) lk_phase = PH_IDLE;
      end
      PH_P_S: begin
        if (b == CH_S) lk_phase = PH_P_EQ;
        else line_error(b, 1'b1);
      end
      PH_P_EQ: begin
        if (b == CH_EQ) lk_phase = PH_P_DIG;
        else line_error(b, 1'b1);
      end
      PH_P_DIG: begin
        if (b >= CH_ONE && b <= CH_FOUR) begin
          ps_digit = 3'(b - CH_ZERO);
          lk_phase = PH_P_END;
        end else begin
          line_error(b, 1'b1);
        end
      end
      PH_P_END: begin
        if (eol_b(b)) begin
          put(K_POWER, 8'd0, 11'sd0, ps_digit);
          ps_queued = 3'd0;
          recovered();
          awaiting = 1'b0;
          lk_phase = PH_IDLE;
          after_line();
        end else begin
          line_error(b, 1'b1);
        end
      end
      PH_R_T: begin
        if (b == CH_T) lk_phase = PH_R_EQ;
        else line_error(b, 1'b1);
      end
      PH_R_EQ: begin
        if (b == CH_EQ) lk_phase = PH_R_FIRST;
        else line_error(b, 1'b1);
      end
      PH_R_FIRST: begin
        if (digit_b(b)) begin
          deg_acc  = 10'(b - CH_ZERO);
          deg_neg  = 1'b0;
          lk_phase = PH_R_POS2;
        end else if (b == CH_MINUS) begin
          deg_acc  = 10'd0;
          deg_neg  = 1'b1;
          lk_phase = PH_R_NEG1;
        end else begin
          line_error(b, 1'b1);
        end
      end
      PH_R_POS2, PH_R_POS3, PH_R_NEG1, PH_R_NEG2: begin
        // accumulate one decimal digit
        if (digit_b(b)) begin
          deg_acc = 10'(deg_acc * 10 + (b - CH_ZERO));
          if (lk_phase == PH_R_POS2) lk_phase = PH_R_POS3;
          else if (lk_phase == PH_R_NEG1) lk_phase = PH_R_NEG2;
          else lk_phase = PH_R_C;
        end else begin
          line_error(b, 1'b1);
        end
      end
      PH_R_C: begin
        if (b == CH_C) lk_phase = PH_R_END;
        else line_error(b, 1'b1);
      end
      PH_R_END: begin
        if (eol_b(b)) begin
          t = {1'b0, deg_acc};
          if (deg_neg) t = -t;
          put(K_TEMP, 8'd0, t, 3'd0);
          recovered();
          awaiting = 1'b0;
          lk_phase = PH_IDLE;
          after_line();
        end else begin
          line_error(b, 1'b1);
        end
      end
      default: lk_phase = PH_IDLE;
    endcase
  endfunction

  function automatic void tick_step();
    if (!awaiting) begin
      send_poll();
      return;
    end
    if (tick_cnt < 4'd15) tick_cnt = tick_cnt + 4'd1;
    // give up on the reply and retry
    if (tick_cnt >= tmo_ticks) begin
      throttle(K_NORESP);
      awaiting = 1'b0;
      if (ps_queued != 3'd0) send_power();
      else send_poll();
    end
  endfunction

  function automatic void power_step(input logic [2:0] lvl);
    if (lvl < 3'd1 || lvl > 3'd4) begin
      put(K_BADLVL, 8'd0, 11'sd0, 3'd0);
      return;
    end
    ps_queued = lvl;
    if (!awaiting) send_power();
  endfunction

  function automatic void amp_link_step(input cmd_t c, input logic [7:0] b,
                                        input logic [2:0] lvl);
    step_out.delete();
    case (c)
      CMD_RX:    rx_parse(b);
      CMD_TICK:  tick_step();
      CMD_POWER: power_step(lvl);
      default: ;
    endcase
    if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offer one transaction from a falling edge; return at the falling edge after acceptance
  task automatic offer(input cmd_t c, input logic [7:0] b, input logic [2:0] lvl);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_cmd   = c;
    in_rx    = b;
    in_lvl   = lvl;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    amp_link_step(c, b, lvl);
    if (typed_q.size() != 0) begin
      foreach (typed_q[i]) link_out_q.push_back(typed_q[i]);
      typed_q.delete();
    end else begin
      foreach (step_out[i]) link_out_q.push_back(step_out[i]);
    end
    if (c != CMD_NONE) items_sent++;
    @(negedge clk);
  endtask

  // Mostly well-formed reply lines with random content, plus ticks, requests and noise
  task automatic random_traffic(input int n_items, input bit mid_pause);
    int         start;
    int         pick;
    int         at;
    bit         paused;
    logic [7:0] ws;
    logic [7:0] line_q[$];
    start  = items_sent;
    paused = 1'b0;
    while (items_sent - start < n_items) begin
      pick = int'($urandom_range(99));
      line_q.delete();
      if (pick < 15) begin
        offer(CMD_TICK, 8'($urandom_range(255)), 3'($urandom_range(7)));
      end else if (pick < 25) begin
        offer(CMD_POWER, 8'($urandom_range(255)),
              ($urandom_range(3) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(1, 4)));
      end else if (pick < 30) begin
        offer(CMD_NONE, 8'($urandom_range(255)), 3'($urandom_range(7)));
      end else if (pick < 40) begin
        offer(CMD_RX, 8'($urandom_range(255)), 3'($urandom_range(7)));
      end else begin
        // build one reply line
        if ($urandom_range(3) == 0) begin
          case ($urandom_range(3))
            0:       ws = CH_SPACE;
            1:       ws = CH_TAB;
            2:       ws = CH_CR;
            default: ws = CH_LF;
          endcase
          line_q.push_back(ws);
        end
        if ($urandom_range(1) == 0) begin
          line_q.push_back(CH_P);
          line_q.push_back(CH_S);
          line_q.push_back(CH_EQ);
          line_q.push_back(CH_ONE + 8'($urandom_range(3)));
        end else begin
          line_q.push_back(CH_R);
          line_q.push_back(CH_T);
          line_q.push_back(CH_EQ);
          if ($urandom_range(1) == 0) begin
            repeat (3) line_q.push_back(CH_ZERO + 8'($urandom_range(9)));
          end else begin
            line_q.push_back(CH_MINUS);
            repeat (2) line_q.push_back(CH_ZERO + 8'($urandom_range(9)));
          end
          line_q.push_back(CH_C);
        end
        line_q.push_back(($urandom_range(1) == 0) ? CH_CR : CH_LF);
        // break some lines with one random byte
        if (pick >= 88) begin
          at = int'($urandom_range(line_q.size() - 1));
          line_q[at] = 8'($urandom_range(255));
        end
        foreach (line_q[i]) begin
          if ($urandom_range(9) == 0) offer(CMD_TICK, 8'($urandom_range(255)), 3'($urandom_range(7)));
          offer(CMD_RX, line_q[i], 3'($urandom_range(7)));
        end
      end
      // hold the sender once until every result is back
      if (mid_pause && !paused && items_sent - start >= n_items / 2) begin
        paused = 1'b1;
        in_valid = 1'b0;
        while (link_out_q.size() != 0) @(negedge clk);
      end
    end
    in_valid = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  task automatic report(input string what);
    if (fail_cnt < MAX_PRINTS) $display("%0t ns  mismatch: %s", $time, what);
    fail_cnt++;
  endtask

  // Drive ready; a requested hold-off is counted here
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else if (hold_ask != hold_taken) begin
      hold_taken = hold_ask;
      hold_left  = HOLD_CYCLES - 1;
      out_ready  = 1'b0;
    end else begin
      out_ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare each result transaction with the oldest one pending
  always @(posedge clk) begin
    link_out_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (link_out_q.size() == 0) begin
        report($sformatf("result kind %0d with none pending", kind));
      end else begin
        want = link_out_q.pop_front();
        if (kind !== want.kind)
          report($sformatf("kind %0d, want %0d", kind, want.kind));
        if (tx_byte !== want.tx)
          report($sformatf("tx_byte %02h, want %02h", tx_byte, want.tx));
        if (temperature !== want.temp)
          report($sformatf("temperature %0d, want %0d", temperature, want.temp));
        if (power_reported !== want.pw)
          report($sformatf("power_reported %0d, want %0d", power_reported, want.pw));
        if (last !== want.last)
          report($sformatf("last %0b, want %0b", last, want.last));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, link_out_q.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    link_out_t typed;

    // directed: poll, hottest reading, bad levels, power request, ignored command,
    // junk start byte with skip, timeout, whitespace, power reply with recovery and
    // re-poll, error inside a reply
    dir_rows[0]  = '{CMD_TICK,  8'h00,    3'd0, 3'd4, K_TX, {CH_R, CH_T, CH_QUERY, CH_CR}, 11'sd0};
    dir_rows[1]  = '{CMD_RX,    CH_R,     3'd7, 3'd0, K_TX, NO_TX, 11'sd0};
    dir_rows[2]  = '{CMD_RX,    CH_T,     3'd0, 3'd0, K_TX, NO_TX, 11'sd0};
    dir_rows[3]  = '{CMD_RX,    CH_EQ,    3'd0, 3'd0, K_TX, NO_TX, 11'sd0};
    dir_rows[4]  = '{CMD_RX,    CH_NINE,  3'd0, 3'd0, K_TX, NO_TX, 11'sd0};
    dir_rows[5]  = '{CMD_RX,    CH_NINE,  3'd0, 3'd0, K_TX, NO_TX, 11'sd0};
    dir_rows[6]  = '{CMD_RX,    CH_NINE,  3'd0, 3'd0, K_TX, NO_TX, 11'sd0};
    dir_rows[7]  = '{CMD_RX,    CH_C,     3'd0, 3'd0, K_TX, NO_TX, 11'sd0};
    dir_rows[8]  = '{CMD_RX,    CH_CR,    3'd0, 3'd1, K_TEMP, NO_TX, 11'sd999};
    dir_rows[9]  = '{CMD_POWER, 8'h00,    3'd0, 3'd1, K_BADLVL, NO_TX, 11'sd0};
    dir_rows[10] = '{CMD_POWER, 8'hFF,    3'd7, 3'd1, K_BADLVL, NO_TX, 11'sd0};
    dir_rows[11] = '{CMD_POWER, 8'h00,    3'd4, 3'd4, K_TX, {CH_P, CH_S, CH_FOUR, CH_CR}, 11'sd0};
    dir_rows[12] = '{CMD_NONE,  8'hFF,    3'd7, 3'd0, K_TX, NO_TX, 11'sd0};
    dir_rows[13] = '{CMD_RX,    8'hFF,    3'd0, 3'd0, K_TX, NO_TX, 11'sd0};
    dir_rows[14] = '{CMD_RX,    8'h00,    3'd0, 3'd0, K_TX, NO_TX, 11'sd0};
    dir_rows[15] = '{CMD_RX,    CH_LF,    3'd0, 3'd0, K_TX, NO_TX, 11'sd0};
    dir_rows[16] = '{CMD_TICK,  8'h00,    3'd0, 3'd4, K_TX, {CH_R, CH_T, CH_QUERY, CH_CR}, 11'sd0};
    dir_rows[17] = '{CMD_TICK,  8'h00,    3'd0, 3'd0, K_TX, NO_TX, 11'sd0};
    dir_rows[18] = '{CMD_TICK,  8'h00,    3'd0, 3'd0, K_TX, NO_TX, 11'sd0};
    dir_rows[19] = '{CMD_RX,    CH_SPACE, 3'd0, 3'd0, K_TX, NO_TX, 11'sd0};
    dir_rows[20] = '{CMD_RX,    CH_P,     3'd0, 3'd0, K_TX, NO_TX, 11'sd0};
    dir_rows[21] = '{CMD_RX,    CH_S,     3'd0, 3'd0, K_TX, NO_TX, 11'sd0};
    dir_rows[22] = '{CMD_RX,    CH_EQ,    3'd0, 3'd0, K_TX, NO_TX, 11'sd0};
    dir_rows[23] = '{CMD_RX,    CH_ZERO + 8'd3, 3'd0, 3'd0, K_TX, NO_TX, 11'sd0};
    dir_rows[24] = '{CMD_RX,    CH_CR,    3'd0, 3'd0, K_TX, NO_TX, 11'sd0};
    dir_rows[25] = '{CMD_RX,    CH_R,     3'd0, 3'd0, K_TX, NO_TX, 11'sd0};
    dir_rows[26] = '{CMD_RX,    CH_EQ,    3'd0, 3'd1, K_SYNTAX, NO_TX, 11'sd0};
    dir_rows[27] = '{CMD_RX,    CH_LF,    3'd0, 3'd0, K_TX, NO_TX, 11'sd0};

    repeat (10) @(negedge clk);
    rst = 1'b0;

    // walk the directed table with reset register values
    for (int i = 0; i < DIR_ROWS; i++) begin
      for (int j = 0; j < int'(dir_rows[i].n_typed); j++) begin
        typed.kind = dir_rows[i].kind;
        typed.tx   = (dir_rows[i].kind == K_TX) ? dir_rows[i].txs[31 - 8 * j -: 8] : 8'd0;
        typed.temp = (dir_rows[i].kind == K_TEMP) ? dir_rows[i].val : 11'sd0;
        typed.pw   = 3'd0;
        typed.last = (j == int'(dir_rows[i].n_typed) - 1);
        typed_q.push_back(typed);
      end
      offer(dir_rows[i].cmd, dir_rows[i].rx, dir_rows[i].lvl);
    end
    in_valid = 1'b0;

    // random phases, each under its own register setting and handshake mix
    for (int p = 0; p < NUM_PHASES; p++) begin
      while (link_out_q.size() != 0) @(negedge clk);
      repeat (SETTLE_CYCLES) @(negedge clk);
      cfg_wr_en = 1'b1;
      cfg_index = CFG_TIMEOUT;
      cfg_data  = TMO_SET[p];
      @(negedge clk);
      cfg_index = CFG_ERR_LIM;
      cfg_data  = LIM_SET[p];
      @(negedge clk);
      cfg_wr_en = 1'b0;
      tmo_ticks = TMO_SET[p];
      err_limit = LIM_SET[p];
      send_idle_pct  = IDLE_SET[p];
      recv_stall_pct = STALL_SET[p];
      // long receiver hold-off while the sender keeps pushing
      if (p == 0) hold_ask++;
      random_traffic(ITEMS_PER_PHASE, p == NUM_PHASES - 1);
    end

    // drain, then watch for stray results
    while (link_out_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d transactions over reset and four register settings, with idle",
             items_sent);
    $display("and stall mixes and one long output hold; %0d results compared, %0d mismatches.",
             results_seen, fail_cnt);
    if (fail_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
